// ----- rtl/core/mssf_pkg.sv -----
// package: shared types, codes, segment patterns and helper functions of the display formatter
`timescale 1ns / 1ps
package mssf_pkg;

    localparam int DIV_STEPS = 32;
    localparam int BCD_STEPS = 32;

    typedef enum logic [2:0] {
        OP_CLOCK   = 3'd0,
        OP_STEPS   = 3'd1,
        OP_WATCH   = 3'd2,
        OP_SPEED   = 3'd3,
        OP_MESSAGE = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        CFG_STRIDE_SHORT = 2'd0,
        CFG_STRIDE_LONG  = 2'd1,
        CFG_USE_LONG     = 2'd2
    } t_cfg_index;

    localparam logic [11:0] STRIDE_SHORT_RESET = 12'd600;
    localparam logic [11:0] STRIDE_LONG_RESET  = 12'd900;
    localparam logic [4:0]  MAX_DECADE         = 5'd9;

    localparam logic [7:0] SEG_BLANK = 8'hFF;
    localparam logic [7:0] SEG_C     = 8'hC6;
    localparam logic [7:0] SEG_L     = 8'hC7;
    localparam logic [7:0] SEG_R     = 8'hAF;
    localparam logic [7:0] SEG_D     = 8'hA1;
    localparam logic [7:0] SEG_S     = 8'h92;
    localparam logic [7:0] SEG_A     = 8'h88;
    localparam logic [7:0] SEG_TICK  = 8'hDF;
    localparam logic [7:0] DP_ON     = 8'h7F;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [1:0]  msg;
        logic [15:0] pair_digits;
        logic        invalid;
        logic        zero;
    } t_ctl;

    function automatic logic [7:0] seg_digit(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'hC0;
            4'd1:    s = 8'hF9;
            4'd2:    s = 8'hA4;
            4'd3:    s = 8'hB0;
            4'd4:    s = 8'h99;
            4'd5:    s = 8'h92;
            4'd6:    s = 8'h82;
            4'd7:    s = 8'hF8;
            4'd8:    s = 8'h80;
            4'd9:    s = 8'h90;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    // two low decimal digits of a 7-bit value, tens in the upper nibble
    function automatic logic [7:0] bcd2(input logic [6:0] v);
        logic [6:0] r;
        logic [3:0] t;
        r = v;
        t = 4'd0;
        if (r >= 7'd80) begin r = r - 7'd80; t = t + 4'd8; end
        if (r >= 7'd40) begin r = r - 7'd40; t = t + 4'd4; end
        if (r >= 7'd20) begin r = r - 7'd20; t = t + 4'd2; end
        if (r >= 7'd10) begin r = r - 7'd10; t = t + 4'd1; end
        if (t >= 4'd10) begin
            t = t - 4'd10;
        end
        return {t, r[3:0]};
    endfunction

    function automatic logic [31:0] pow10(input logic [3:0] k);
        logic [31:0] p;
        case (k)
            4'd0:    p = 32'd1;
            4'd1:    p = 32'd10;
            4'd2:    p = 32'd100;
            4'd3:    p = 32'd1000;
            4'd4:    p = 32'd10000;
            4'd5:    p = 32'd100000;
            4'd6:    p = 32'd1000000;
            4'd7:    p = 32'd10000000;
            4'd8:    p = 32'd100000000;
            4'd9:    p = 32'd1000000000;
            default: p = 32'd1;
        endcase
        return p;
    endfunction

endpackage

// ----- rtl/core/multimode_seven_segment_formatter_core.sv -----
// top level: pipelined four-digit seven-segment formatter with divider and bcd stages
`timescale 1ns / 1ps
// Usage
// Input stream (i_s_tvalid/o_s_tready/i_s_tdata) carries one refresh request per transfer.
// Output stream (o_m_tvalid/i_m_tready/o_m_tdata) returns four active-low segment codes
// and the speed flag for every request, in order.
// Config: i_cfg_we writes i_cfg_wdata into register i_cfg_addr (0 short stride,
// 1 long stride, 2 long stride select); index 3 is ignored. Write only while idle.
// Throughput: one request per cycle unless the receiver stalls; the 32-stage
// restoring divider (one quotient bit per stage) and the 32-stage binary to bcd
// shifter are fully pipelined.
// Steps mode divides by a power of ten taken from a table; speed mode divides
// the wrapped distance by the elapsed seconds; both share the divider.
// Reset clears all valid bits and loads the stride registers with 600, 900 and 0.
// When the receiver stalls the whole pipeline holds and o_s_tready drops, so
// nothing is lost or repeated.
module multimode_seven_segment_formatter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // opcode[2:0] show_hours[3] hours[8:4] minutes[14:9] seconds[20:15]
    // step_count[52:21] decade_shift[56:53] watch_seconds[63:57]
    // watch_hundredths[70:64] message_select[72:71], zero fill above
    input  logic [79:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // segments_digit0[7:0] segments_digit1[15:8] segments_digit2[23:16]
    // segments_digit3[31:24] speed_invalid[32], zero fill above
    output logic [39:0] o_m_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [11:0] i_cfg_wdata
);

    localparam int DS = mssf_pkg::DIV_STEPS;
    localparam int BS = mssf_pkg::BCD_STEPS;

    logic [11:0] r_stride_short;
    logic [11:0] r_stride_long;
    logic        r_use_long;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride_short <= mssf_pkg::STRIDE_SHORT_RESET;
            r_stride_long  <= mssf_pkg::STRIDE_LONG_RESET;
            r_use_long     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                mssf_pkg::CFG_STRIDE_SHORT: r_stride_short <= i_cfg_wdata;
                mssf_pkg::CFG_STRIDE_LONG:  r_stride_long  <= i_cfg_wdata;
                mssf_pkg::CFG_USE_LONG:     r_use_long     <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // whole pipeline advances together
    logic w_en;
    logic r_out_valid;
    assign w_en       = !r_out_valid || i_m_tready;
    assign o_s_tready = w_en;

    // input fields
    logic [2:0]  w_opcode;
    logic        w_show_hours;
    logic [4:0]  w_hours;
    logic [5:0]  w_minutes;
    logic [5:0]  w_seconds;
    logic [31:0] w_step_count;
    logic [3:0]  w_decade;
    logic [6:0]  w_watch_s;
    logic [6:0]  w_watch_h;
    logic [1:0]  w_msg;
    assign w_opcode     = i_s_tdata[2:0];
    assign w_show_hours = i_s_tdata[3];
    assign w_hours      = i_s_tdata[8:4];
    assign w_minutes    = i_s_tdata[14:9];
    assign w_seconds    = i_s_tdata[20:15];
    assign w_step_count = i_s_tdata[52:21];
    assign w_decade     = i_s_tdata[56:53];
    assign w_watch_s    = i_s_tdata[63:57];
    assign w_watch_h    = i_s_tdata[70:64];
    assign w_msg        = i_s_tdata[72:71];

    // stage 0: distance product, elapsed seconds, divisor and two-digit pairs
    logic [11:0]     w_stride;
    logic [31:0]     w_dist;
    logic [16:0]     w_elapsed;
    logic [31:0]     n_num0;
    logic [31:0]     n_den0;
    mssf_pkg::t_ctl  n_ctl0;
    logic [7:0]      w_pair_hi;
    logic [7:0]      w_pair_lo;

    always_comb begin
        w_stride    = r_use_long ? r_stride_long : r_stride_short;
        // only the low 32 bits of the distance are kept
        w_dist      = w_step_count * {20'd0, w_stride};
        w_elapsed   = ({12'd0, w_hours} * 17'd3600) + ({11'd0, w_minutes} * 17'd60)
                    + {11'd0, w_seconds};
        if (w_opcode == mssf_pkg::OP_WATCH) begin
            w_pair_hi = mssf_pkg::bcd2(w_watch_s);
            w_pair_lo = mssf_pkg::bcd2(w_watch_h);
        end else if (w_show_hours) begin
            w_pair_hi = mssf_pkg::bcd2({2'd0, w_hours});
            w_pair_lo = mssf_pkg::bcd2({1'b0, w_minutes});
        end else begin
            w_pair_hi = mssf_pkg::bcd2({1'b0, w_minutes});
            w_pair_lo = mssf_pkg::bcd2({1'b0, w_seconds});
        end
        n_ctl0.opcode      = w_opcode;
        n_ctl0.msg         = w_msg;
        n_ctl0.pair_digits = {w_pair_hi, w_pair_lo};
        n_ctl0.invalid     = (w_opcode == mssf_pkg::OP_SPEED) && (w_elapsed == 17'd0);
        n_ctl0.zero        = (w_opcode == mssf_pkg::OP_STEPS)
                           && ({1'b0, w_decade} > mssf_pkg::MAX_DECADE);
        if (w_opcode == mssf_pkg::OP_SPEED) begin
            n_num0 = w_dist;
            n_den0 = {15'd0, w_elapsed};
        end else begin
            n_num0 = w_step_count;
            n_den0 = mssf_pkg::pow10(w_decade);
        end
    end

    // divider pipeline, index 0 is the stage 0 register
    logic           r_div_v   [0:DS];
    logic [31:0]    r_div_rem [0:DS];
    logic [31:0]    r_div_num [0:DS];
    logic [31:0]    r_div_den [0:DS];
    mssf_pkg::t_ctl r_div_ctl [0:DS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_v[0] <= 1'b0;
        end else if (w_en) begin
            r_div_v[0] <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_div_rem[0] <= 32'd0;
            r_div_num[0] <= n_num0;
            r_div_den[0] <= n_den0;
            r_div_ctl[0] <= n_ctl0;
        end
    end

    for (genvar s = 1; s <= DS; s++) begin : g_div
        logic [32:0] w_trial;
        logic [32:0] w_diff;
        assign w_trial = {r_div_rem[s-1], r_div_num[s-1][31]};
        assign w_diff  = w_trial - {1'b0, r_div_den[s-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_div_v[s] <= 1'b0;
            end else if (w_en) begin
                r_div_v[s] <= r_div_v[s-1];
            end
        end

        // quotient bits shift in as dividend bits shift out
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_div_rem[s] <= w_diff[32] ? w_trial[31:0] : w_diff[31:0];
                r_div_num[s] <= {r_div_num[s-1][30:0], !w_diff[32]};
                r_div_den[s] <= r_div_den[s-1];
                r_div_ctl[s] <= r_div_ctl[s-1];
            end
        end
    end

    // binary to bcd, four digits kept so the result is the value mod 10000
    logic           r_bcd_v   [0:BS];
    logic [15:0]    r_bcd     [0:BS];
    logic [31:0]    r_bin     [0:BS];
    mssf_pkg::t_ctl r_bcd_ctl [0:BS];
    logic [31:0]    n_bin0;

    always_comb begin
        if (r_div_ctl[DS].zero || r_div_ctl[DS].invalid) begin
            n_bin0 = 32'd0;
        end else if (r_div_ctl[DS].opcode == mssf_pkg::OP_SPEED) begin
            n_bin0 = {16'd0, r_div_num[DS][15:0]};
        end else begin
            n_bin0 = r_div_num[DS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcd_v[0] <= 1'b0;
        end else if (w_en) begin
            r_bcd_v[0] <= r_div_v[DS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bcd[0]     <= 16'd0;
            r_bin[0]     <= n_bin0;
            r_bcd_ctl[0] <= r_div_ctl[DS];
        end
    end

    for (genvar s = 1; s <= BS; s++) begin : g_bcd
        logic [15:0] w_adj;
        always_comb begin
            for (int j = 0; j < 4; j++) begin
                w_adj[j*4 +: 4] = (r_bcd[s-1][j*4 +: 4] >= 4'd5)
                                ? r_bcd[s-1][j*4 +: 4] + 4'd3 : r_bcd[s-1][j*4 +: 4];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_bcd_v[s] <= 1'b0;
            end else if (w_en) begin
                r_bcd_v[s] <= r_bcd_v[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_bcd[s]     <= {w_adj[14:0], r_bin[s-1][31]};
                r_bin[s]     <= {r_bin[s-1][30:0], 1'b0};
                r_bcd_ctl[s] <= r_bcd_ctl[s-1];
            end
        end
    end

    // output stage: segment encoding
    mssf_pkg::t_ctl w_fc;
    logic [15:0]    w_dig;
    logic [7:0]     n_d0;
    logic [7:0]     n_d1;
    logic [7:0]     n_d2;
    logic [7:0]     n_d3;
    logic [39:0]    r_out;

    always_comb begin
        w_fc  = r_bcd_ctl[BS];
        w_dig = r_bcd[BS];
        n_d0  = mssf_pkg::SEG_BLANK;
        n_d1  = mssf_pkg::SEG_BLANK;
        n_d2  = mssf_pkg::SEG_BLANK;
        n_d3  = mssf_pkg::SEG_BLANK;
        case (w_fc.opcode)
            mssf_pkg::OP_CLOCK, mssf_pkg::OP_WATCH: begin
                n_d0 = mssf_pkg::seg_digit(w_fc.pair_digits[15:12]);
                n_d1 = mssf_pkg::seg_digit(w_fc.pair_digits[11:8]) & mssf_pkg::DP_ON;
                n_d2 = mssf_pkg::seg_digit(w_fc.pair_digits[7:4]);
                n_d3 = mssf_pkg::seg_digit(w_fc.pair_digits[3:0]);
            end
            mssf_pkg::OP_STEPS, mssf_pkg::OP_SPEED: begin
                n_d0 = mssf_pkg::seg_digit(w_dig[15:12]);
                n_d1 = mssf_pkg::seg_digit(w_dig[11:8]);
                n_d2 = mssf_pkg::seg_digit(w_dig[7:4]);
                n_d3 = mssf_pkg::seg_digit(w_dig[3:0]);
                if (w_fc.opcode == mssf_pkg::OP_SPEED) begin
                    n_d0 = n_d0 & mssf_pkg::DP_ON;
                end
            end
            mssf_pkg::OP_MESSAGE: begin
                case (w_fc.msg)
                    2'd0: begin
                        n_d0 = mssf_pkg::SEG_C; n_d1 = mssf_pkg::SEG_L;
                        n_d2 = mssf_pkg::SEG_R; n_d3 = mssf_pkg::SEG_BLANK;
                    end
                    2'd1: begin
                        n_d0 = mssf_pkg::SEG_C; n_d1 = mssf_pkg::SEG_L;
                        n_d2 = mssf_pkg::SEG_R; n_d3 = mssf_pkg::SEG_D;
                    end
                    2'd2: begin
                        n_d0 = mssf_pkg::SEG_S;    n_d1 = mssf_pkg::SEG_A;
                        n_d2 = mssf_pkg::SEG_TICK; n_d3 = mssf_pkg::SEG_D;
                    end
                    default: begin
                        n_d0 = mssf_pkg::SEG_C; n_d1 = mssf_pkg::SEG_L;
                        n_d2 = mssf_pkg::SEG_R; n_d3 = mssf_pkg::SEG_A;
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_bcd_v[BS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= {7'd0, w_fc.invalid, n_d3, n_d2, n_d1, n_d0};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    // checks
    a_ready_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready does not follow output stall");

    a_invalid_shows_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[32]) |->
        (o_m_tdata[7:0] == (8'hC0 & mssf_pkg::DP_ON) && o_m_tdata[15:8] == 8'hC0
         && o_m_tdata[23:16] == 8'hC0 && o_m_tdata[31:24] == 8'hC0))
        else $error("zero elapsed time does not show 0000");

    a_pipe_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_div_v[DS]) && $stable(r_bcd_v[BS]) && $stable(r_bcd[BS])))
        else $error("pipeline moved during a stall");

endmodule
